>>> hdl/key_matrix_deferred_debounce_top_defines.svh
// ---------------------------------------------------------------------------
// key matrix debounce assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEFERRED_DEBOUNCE_TOP_DEFINES_SVH
`define KEY_MATRIX_DEFERRED_DEBOUNCE_TOP_DEFINES_SVH

// plain property check
`define KMDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication check
`define KMDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/kmdd_pkg.sv
// ---------------------------------------------------------------------------
// kmdd_pkg
// sizes, codes and controller/datapath interface types of the debouncer
// ---------------------------------------------------------------------------
package kmdd_pkg;

  localparam int NumColumns = 19;
  localparam int NumRows    = 5;

  localparam int ColW    = 5;
  localparam int RowW    = 5;
  localparam int CfgW    = 8;
  localparam int QuietW  = 16;
  localparam int ColIdxW = (NumColumns > 1) ? $clog2(NumColumns) : 1;

  localparam logic [RowW-1:0]   RowMask       = RowW'((64'd1 << NumRows) - 64'd1);
  localparam logic [ColW-1:0]   LastCol       = ColW'(NumColumns - 1);
  localparam logic [ColIdxW-1:0] LastIdx      = ColIdxW'(NumColumns - 1);
  localparam logic [CfgW-1:0]   DebounceReset = 8'd5;
  localparam logic [QuietW-1:0] QuietMax      = '1;

  // item kinds
  localparam logic ActSample = 1'b0;
  localparam logic ActTick   = 1'b1;

  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic burst_load;  // load next committed column into output register
  } cmd_t;

  typedef struct packed {
    logic commit;      // current input would start a commit burst
    logic burst_last;  // burst counter at the last column
    logic out_free;    // output register can take a beat
  } status_t;

endpackage

>>> hdl/kmdd_ctrl.sv
// ---------------------------------------------------------------------------
// kmdd_ctrl
// accepts input beats and sequences the commit burst
// ---------------------------------------------------------------------------
`include "key_matrix_deferred_debounce_top_defines.svh"

module kmdd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kmdd_pkg::status_t status_i,
  output kmdd_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    StIdle  = 2'b01,
    StBurst = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    in_ready_o       = (state_q == StIdle);
    cmd_o.accept     = in_valid_i && in_ready_o;
    cmd_o.burst_load = (state_q == StBurst) && status_i.out_free;
    state_d          = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_o.accept && status_i.commit) state_d = StBurst;
      end
      StBurst: begin
        if (cmd_o.burst_load && status_i.burst_last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `KMDD_ASSERT(a_no_accept_in_burst, !(state_q == StBurst && cmd_o.accept),
               "input taken during burst")
  `KMDD_ASSERT_NEXT(a_commit_starts_burst, cmd_o.accept && status_i.commit,
                    state_q == StBurst, "commit did not start burst")
  `KMDD_ASSERT_NEXT(a_burst_runs_to_end,
                    state_q == StBurst && !(cmd_o.burst_load && status_i.burst_last),
                    state_q == StBurst, "burst ended early")

endmodule

>>> hdl/kmdd_dp.sv
// ---------------------------------------------------------------------------
// kmdd_dp
// raw matrix, quiet timer, pending flag, burst counter and output register
// ---------------------------------------------------------------------------
module kmdd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kmdd_pkg::cmd_t                cmd_i,
  output kmdd_pkg::status_t             status_o,
  input  logic                          cfg_valid_i,
  input  logic [kmdd_pkg::CfgW-1:0]     cfg_debounce_ms_i,
  input  logic                          action_i,
  input  logic [kmdd_pkg::ColW-1:0]     column_index_i,
  input  logic [kmdd_pkg::RowW-1:0]     row_bits_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [kmdd_pkg::ColW-1:0]     out_column_o,
  output logic [kmdd_pkg::RowW-1:0]     out_rows_o,
  output logic                          last_o
);

  logic [kmdd_pkg::RowW-1:0]    raw_q [kmdd_pkg::NumColumns];
  logic [kmdd_pkg::CfgW-1:0]    debounce_q;
  logic [kmdd_pkg::QuietW-1:0]  quiet_q, quiet_d;
  logic                         pending_q, pending_d;
  logic [kmdd_pkg::ColIdxW-1:0] cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  logic [kmdd_pkg::ColW-1:0]    out_col_q;
  logic [kmdd_pkg::RowW-1:0]    out_rows_q;
  logic                         out_last_q;

  logic                         is_sample, in_range, changed, wr_raw;
  logic [kmdd_pkg::ColIdxW-1:0] col_idx, rd_addr;
  logic [kmdd_pkg::RowW-1:0]    rows_m, rd_data;

  always_comb begin
    is_sample = (action_i == kmdd_pkg::ActSample);
    in_range  = ({1'b0, column_index_i} < 6'(kmdd_pkg::NumColumns));
    col_idx   = column_index_i[kmdd_pkg::ColIdxW-1:0];
    rows_m    = row_bits_i & kmdd_pkg::RowMask;
    // one read port: burst counter on a burst load, sample column otherwise
    rd_addr   = cmd_i.burst_load ? cnt_q : col_idx;
    rd_data   = raw_q[rd_addr];
    changed   = is_sample && in_range && (rd_data != rows_m);
    wr_raw    = cmd_i.accept && changed;

    status_o.commit     = is_sample && (column_index_i == kmdd_pkg::LastCol) && !changed &&
                          pending_q && (quiet_q > {8'd0, debounce_q});
    status_o.burst_last = (cnt_q == kmdd_pkg::LastIdx);
    status_o.out_free   = !out_valid_q || out_ready_i;

    quiet_d   = quiet_q;
    pending_d = pending_q;
    if (cmd_i.accept && !is_sample) begin
      if (quiet_q != kmdd_pkg::QuietMax) quiet_d = quiet_q + 16'd1;
    end
    if (wr_raw) begin
      quiet_d   = '0;
      pending_d = 1'b1;
    end

    cnt_d = cnt_q;
    if (cmd_i.burst_load) begin
      if (status_o.burst_last) begin
        cnt_d     = '0;
        pending_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    out_valid_d = out_valid_q;
    if (cmd_i.burst_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kmdd_pkg::NumColumns; i++) raw_q[i] <= '0;
      debounce_q  <= kmdd_pkg::DebounceReset;
      quiet_q     <= '0;
      pending_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_raw) raw_q[col_idx] <= rows_m;
      if (cfg_valid_i) debounce_q <= cfg_debounce_ms_i;
      quiet_q     <= quiet_d;
      pending_q   <= pending_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // committed column goes straight into the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.burst_load) begin
      out_col_q  <= kmdd_pkg::ColW'(cnt_q);
      out_rows_q <= rd_data;
      out_last_q <= status_o.burst_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_column_o = out_col_q;
  assign out_rows_o   = out_rows_q;
  assign last_o       = out_last_q;

endmodule

>>> hdl/key_matrix_deferred_debounce_top.sv
// ---------------------------------------------------------------------------
// key_matrix_deferred_debounce_top
// keyboard matrix debouncer with one global deferred commit timer
// ---------------------------------------------------------------------------
// Each input beat is either a column sample (action 0) or a one millisecond
// tick (action 1), and is taken while no commit burst runs. A
// sample that differs from the stored raw column replaces it, flags a pending
// change and restarts the quiet timer; ticks advance the timer, which
// saturates at 65535. Samples of columns beyond the matrix are dropped. When
// the last column is sampled unchanged, a change is pending and the quiet time
// is above debounce_ms, the block reports the whole raw matrix as the new
// debounced state: one output beat per column, column 0 first, last high on
// the final one. The burst takes one cycle per column when the
// sink is always ready, paced by the single read port of the raw column store
// and the output register; no input beat is taken until the last column has
// been loaded. debounce_ms resets to 5 and is written through the cfg port,
// which is always ready and should only be used while the block is idle.
// ---------------------------------------------------------------------------
module key_matrix_deferred_debounce_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [kmdd_pkg::CfgW-1:0] cfg_debounce_ms_i,
  // input beats
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      action_i,
  input  logic [kmdd_pkg::ColW-1:0] column_index_i,
  input  logic [kmdd_pkg::RowW-1:0] row_bits_i,
  // committed column beats
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [kmdd_pkg::ColW-1:0] out_column_o,
  output logic [kmdd_pkg::RowW-1:0] out_rows_o,
  output logic                      last_o
);

  kmdd_pkg::cmd_t    cmd;
  kmdd_pkg::status_t status;

  // register write needs no wait state
  assign cfg_ready_o = 1'b1;

  // controller: beat acceptance and burst sequencing
  kmdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: matrix store, timer, pending flag, output register
  kmdd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_debounce_ms_i (cfg_debounce_ms_i),
    .action_i          (action_i),
    .column_index_i    (column_index_i),
    .row_bits_i        (row_bits_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .out_column_o      (out_column_o),
    .out_rows_o        (out_rows_o),
    .last_o            (last_o)
  );

endmodule

>>> sim/key_matrix_deferred_debounce_top_tb.sv
// ---------------------------------------------------------------------------
// key_matrix_deferred_debounce_top_tb
// self-checking bench: directed and random key scans against a local model
// ---------------------------------------------------------------------------
// A driver feeds sample and tick beats from a queue, and a monitor predicts
// every commit burst on input acceptance and checks each output beat against
// the oldest expected column. The debounce limit is rewritten between phases
// while the block is idle. Phases change how often each side idles, one
// phase holds off the sink long enough to back up the input, and the last
// phase checks the top limit before a final random scan.
// ---------------------------------------------------------------------------
module key_matrix_deferred_debounce_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmdd_pkg::*;

  localparam int IdleLimit  = 5000;   // cycles without any beat before giving up
  localparam int HoldCycles = 300;    // long sink hold-off
  localparam int DrainPad   = 40;     // covers one full commit burst and then some

  typedef struct packed {
    logic            action;
    logic [ColW-1:0] column;
    logic [RowW-1:0] rows;
  } key_item_t;

  typedef struct packed {
    logic [ColW-1:0] column;
    logic [RowW-1:0] rows;
    logic            last;
  } commit_beat_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // config channel
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CfgW-1:0] cfg_debounce = '0;

  // input channel
  logic            in_valid  = 1'b0;
  logic            in_ready;
  logic            in_action = ActSample;
  logic [ColW-1:0] in_column = '0;
  logic [RowW-1:0] in_rows   = '0;

  // output channel
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [ColW-1:0] out_column;
  logic [RowW-1:0] out_rows;
  logic            out_last;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  key_matrix_deferred_debounce_top DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_debounce_ms_i(cfg_debounce),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (in_action),
    .column_index_i   (in_column),
    .row_bits_i       (in_rows),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_column_o     (out_column),
    .out_rows_o       (out_rows),
    .last_o           (out_last)
  );

  // -------------------------------------------------------------------------
  // bench state
  // -------------------------------------------------------------------------
  key_item_t    scan_items_q[$];     // beats waiting to be offered
  commit_beat_t commit_beats_q[$];   // committed columns still to come out

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;          // ask the sink for one long hold-off
  int hold_left     = 0;
  bit in_beat_taken  = 1'b0;
  bit cfg_beat_taken = 1'b0;
  int idle_cycles   = 0;
  int error_count   = 0;

  // stimulus-side view of the raw matrix and the limit, used to shape scans
  logic [RowW-1:0] gen_rows[NumColumns];
  int              cur_debounce = DebounceReset;

  // local copy of the debouncer
  logic [RowW-1:0]   raw_cols[NumColumns];
  logic [RowW-1:0]   stable_cols[NumColumns];
  logic              change_pending = 1'b0;
  logic [QuietW-1:0] quiet_ms       = '0;
  logic [CfgW-1:0]   debounce_limit = DebounceReset;

  initial begin
    foreach (raw_cols[c]) begin
      raw_cols[c]    = '0;
      stable_cols[c] = '0;
      gen_rows[c]    = '0;
    end
  end

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // advance the local copy by one accepted beat, queue any commit burst
  task automatic predict_debounce(key_item_t it);
    logic [RowW-1:0] r;
    if (it.action == ActTick) begin
      // ticks only age the quiet counter, which sticks at its maximum
      if (quiet_ms != QuietMax) quiet_ms = quiet_ms + 1'b1;
      return;
    end
    // columns past the matrix are dropped without side effects
    if (it.column >= NumColumns) return;
    r = it.rows & RowMask;
    if (raw_cols[it.column] != r) begin
      raw_cols[it.column] = r;
      change_pending      = 1'b1;
      quiet_ms            = '0;
    end
    if (it.column != LastCol) return;
    // scan end: commit only with a pending change and enough quiet time
    if (!change_pending || quiet_ms <= QuietW'(debounce_limit)) return;
    for (int c = 0; c < NumColumns; c++) begin
      stable_cols[c] = raw_cols[c];
      commit_beats_q.push_back('{ColW'(c), stable_cols[c], 1'(c == NumColumns - 1)});
    end
    change_pending = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // driver: offer queued beats at the falling edge, random sender gaps
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_beat_taken) begin
        if (scan_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          {in_action, in_column, in_rows} <= scan_items_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_beat_taken = 1'b0;
    end
  end

  // sink: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // -------------------------------------------------------------------------
  // monitor: predict on input beats, check output beats, watchdog
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    commit_beat_t exp_beat;
    bit           any_beat;
    if (rst_n) begin
      any_beat = 1'b0;
      if (cfg_valid && cfg_ready) begin
        debounce_limit = cfg_debounce;
        cfg_beat_taken = 1'b1;
        any_beat       = 1'b1;
      end
      if (in_valid && in_ready) begin
        predict_debounce('{in_action, in_column, in_rows});
        in_beat_taken = 1'b1;
        any_beat      = 1'b1;
      end
      if (out_valid && out_ready) begin
        any_beat = 1'b1;
        if (commit_beats_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat column %0d rows %0h last %0b",
                                    out_column, out_rows, out_last));
        end else begin
          exp_beat = commit_beats_q.pop_front();
          if (out_column !== exp_beat.column)
            report_mismatch($sformatf("out_column %0d, expected %0d",
                                      out_column, exp_beat.column));
          if (out_rows !== exp_beat.rows)
            report_mismatch($sformatf("out_rows %0h for column %0d, expected %0h",
                                      out_rows, exp_beat.column, exp_beat.rows));
          if (out_last !== exp_beat.last)
            report_mismatch($sformatf("last %0b for column %0d, expected %0b",
                                      out_last, exp_beat.column, exp_beat.last));
        end
      end
      idle_cycles = any_beat ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("ERROR @%0t: no beat for %0d cycles", $time, IdleLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------
  task automatic push_sample(int col, logic [RowW-1:0] rows);
    scan_items_q.push_back('{ActSample, ColW'(col), rows});
    if (col < NumColumns) gen_rows[col] = rows & RowMask;
  endtask

  // ticks carry random column and row fields, which the block must ignore
  task automatic push_ticks(int n);
    repeat (n) scan_items_q.push_back('{ActTick, ColW'($urandom), RowW'($urandom)});
  endtask

  // well-formed scans with random content, some cut short, some noise mixed in
  task automatic queue_scans(int n);
    bit changing;
    int stop_at;
    logic [RowW-1:0] rows;
    repeat (n) begin
      changing = ($urandom_range(2) != 0);
      stop_at  = ($urandom_range(5) == 0) ? $urandom_range(NumColumns - 2) : NumColumns - 1;
      for (int c = 0; c <= stop_at; c++) begin
        if ($urandom_range(7) == 0) begin
          if ($urandom_range(1))
            push_sample($urandom_range(31, NumColumns), RowW'($urandom));
          else
            push_ticks(1);
        end
        push_ticks($urandom_range(1));
        // let the matrix settle before the scan end half the time
        if (c == NumColumns - 1 && $urandom_range(1))
          push_ticks(cur_debounce + 1 + $urandom_range(2));
        rows = gen_rows[c];
        if (changing && $urandom_range(5) == 0) rows = RowW'($urandom);
        push_sample(c, rows);
      end
    end
  endtask

  // wait until everything queued went in and every column came out
  task automatic wait_for_drain();
    while (scan_items_q.size() != 0 || in_valid) @(posedge clk);
    while (commit_beats_q.size() != 0) @(negedge clk);
    repeat (DrainPad) @(negedge clk);
  endtask

  task automatic write_debounce(int value);
    cfg_debounce <= CfgW'(value);
    cfg_valid    <= 1'b1;
    do @(negedge clk); while (!cfg_beat_taken);
    cfg_beat_taken = 1'b0;
    cfg_valid     <= 1'b0;
    cur_debounce   = value;
  endtask

  // queue n random scans and let them drain
  task automatic run_random(int n);
    queue_scans(n);
    wait_for_drain();
  endtask

  // -------------------------------------------------------------------------
  // test sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: sender idles now and then, sink idles most of the time
    send_idle_pct = 31;
    recv_idle_pct = 69;

    // directed, reset limit of 5
    push_sample(0, 5'h1F);
    push_sample(NumColumns - 1, 5'h10);   // change on scan end, no commit
    push_ticks(6);
    push_sample(NumColumns - 1, 5'h10);   // quiet 6 > 5, commit
    push_sample(NumColumns, 5'h1F);       // out-of-range columns dropped
    push_sample(31, 5'h1F);
    scan_items_q.push_back('{ActTick, '1, '1});
    push_sample(NumColumns - 1, 5'h10);   // nothing pending, no commit
    push_sample(5, 5'h01);
    push_ticks(5);
    push_sample(NumColumns - 1, 5'h10);   // quiet equals limit, no commit
    push_ticks(1);
    push_sample(NumColumns - 1, 5'h10);   // one more ms, commit
    push_sample(0, 5'h00);
    push_ticks(7);
    push_sample(NumColumns - 1, 5'h0F);   // last column change clears quiet first
    push_ticks(6);
    push_sample(NumColumns - 1, 5'h0F);
    wait_for_drain();

    write_debounce(0);
    run_random(1);

    // phase 2: roles swapped, sink held off while a burst is in flight
    send_idle_pct = 69;
    recv_idle_pct = 31;
    write_debounce(3);
    hold_req = 1'b1;
    push_sample(0, gen_rows[0] ^ 5'h01);
    push_ticks(4);
    push_sample(NumColumns - 1, gen_rows[NumColumns - 1]);
    run_random(1);

    // phase 3: no idling, top limit holds a change back, then a small limit
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_debounce(255);
    push_sample(3, gen_rows[3] ^ 5'h04);
    push_ticks(8);
    push_sample(NumColumns - 1, gen_rows[NumColumns - 1]);
    wait_for_drain();
    write_debounce(1);
    run_random(1);

    if (commit_beats_q.size() != 0)
      report_mismatch($sformatf("%0d committed columns never came out",
                                commit_beats_q.size()));
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
